// File: hw/rtl/ryb_rgb_trilinear_convert_core_defines.svh
// Assertion macros shared by the converter checker.
`ifndef RYB_RGB_TRILINEAR_CONVERT_CORE_DEFINES_SVH
`define RYB_RGB_TRILINEAR_CONVERT_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RYBRGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RYBRGB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/rybrgb_pkg.sv
// Types, corner tables and pipeline constants of the RYB/RGB converter.
package rybrgb_pkg;

  typedef logic [2:0][7:0] px_t;

  typedef struct packed {
    logic valid;
    logic dir;
  } ctl_t;

  typedef enum logic {
    DIR_RYB_TO_RGB = 1'b0,
    DIR_RGB_TO_RYB = 1'b1
  } dir_e;

  // Corner colors as unsigned 1.16 fixed point, index = first*4 + second*2 + third.
  localparam logic [16:0] RYB2RGB_CORNER [8][3] = '{
    '{17'd0,     17'd0,     17'd0},
    '{17'd0,     17'd23593, 17'd65536},
    '{17'd58982, 17'd58982, 17'd0},
    '{17'd0,     17'd58982, 17'd13107},
    '{17'd65536, 17'd0,     17'd0},
    '{17'd39322, 17'd0,     17'd65536},
    '{17'd65536, 17'd39322, 17'd0},
    '{17'd65536, 17'd65536, 17'd65536}
  };

  localparam logic [16:0] RGB2RYB_CORNER [8][3] = '{
    '{17'd0,     17'd0,     17'd0},
    '{17'd4588,  17'd5243,  17'd58524},
    '{17'd0,     17'd46793, 17'd24510},
    '{17'd0,     17'd7602,  17'd20513},
    '{17'd58393, 17'd0,     17'd0},
    '{17'd36307, 17'd0,     17'd6554},
    '{17'd0,     17'd59965, 17'd0},
    '{17'd65536, 17'd65536, 17'd65536}
  };

  // Full weight 255*255 and floor(2^32 / 65025) for the reciprocal divide.
  localparam logic [15:0] WEIGHT_NORM  = 16'd65025;
  localparam logic [16:0] WEIGHT_RECIP = 17'd66051;

  localparam int unsigned InterpStages = 7;
  localparam int unsigned SatStages    = 11;
  localparam int unsigned PipeLatency  = InterpStages + SatStages;

endpackage

// File: hw/rtl/rybrgb_interp.sv
// Trilinear interpolation pipeline: weights, corner products, sum, byte divide.
module rybrgb_interp import rybrgb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  ctl_t in_ctl_i,
  input  px_t  in_px_i,
  output ctl_t out_ctl_o,
  output px_t  out_px_o
);

  ctl_t ctl_q [1:7];

  logic [3:0][15:0]        pair_d, pair_q;
  logic [7:0]              c1_q;
  logic [7:0][23:0]        w_d, w_q;
  logic [7:0][2:0][40:0]   prod_d, prod_q;
  logic [2:0][40:0]        lo_d, lo_q, hi_d, hi_q;
  logic [2:0][23:0]        x_d, x_q, x6_q;
  logic [2:0][7:0]         qe_d, qe_q;
  px_t                     res_d, res_q;

  // Advance the valid/direction tag with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= 7; s++) begin
        ctl_q[s] <= '0;
      end
    end else begin
      ctl_q[1] <= in_ctl_i;
      for (int s = 2; s <= 7; s++) begin
        ctl_q[s] <= ctl_q[s-1];
      end
    end
  end

  // Stage 1: products of the first two weight factors.
  always_comb begin
    logic [7:0] na, nb;
    na = 8'd255 - in_px_i[0];
    nb = 8'd255 - in_px_i[1];
    pair_d[0] = 16'(na) * 16'(nb);
    pair_d[1] = 16'(na) * 16'(in_px_i[1]);
    pair_d[2] = 16'(in_px_i[0]) * 16'(nb);
    pair_d[3] = 16'(in_px_i[0]) * 16'(in_px_i[1]);
  end

  // Stage 2: full corner weights.
  always_comb begin
    logic [7:0] nc;
    nc = 8'd255 - c1_q;
    for (int k = 0; k < 8; k++) begin
      w_d[k] = 24'(pair_q[k >> 1]) * 24'(((k & 1) != 0) ? c1_q : nc);
    end
  end

  // Stage 3: weight times corner component.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[k][j] = 41'(w_q[k]) * 41'((ctl_q[2].dir == DIR_RGB_TO_RYB) ?
                       RGB2RYB_CORNER[k][j] : RYB2RGB_CORNER[k][j]);
      end
    end
  end

  // Stage 4/5: sum in two halves, then drop the 0.16 fraction.
  always_comb begin
    logic [40:0] tot;
    for (int j = 0; j < 3; j++) begin
      lo_d[j] = prod_q[0][j] + prod_q[1][j] + prod_q[2][j] + prod_q[3][j];
      hi_d[j] = prod_q[4][j] + prod_q[5][j] + prod_q[6][j] + prod_q[7][j];
    end
    for (int j = 0; j < 3; j++) begin
      tot     = lo_q[j] + hi_q[j];
      x_d[j]  = tot[39:16];
    end
  end

  // Stage 6/7: divide by 65025 via reciprocal, fix the estimate by one.
  always_comb begin
    logic [40:0] e;
    logic [23:0] r;
    for (int j = 0; j < 3; j++) begin
      e        = 41'(x_q[j]) * 41'(WEIGHT_RECIP);
      qe_d[j]  = e[39:32];
    end
    for (int j = 0; j < 3; j++) begin
      r          = x6_q[j] - 24'(qe_q[j]) * 24'(WEIGHT_NORM);
      res_d[j]   = qe_q[j] + 8'(r >= 24'(WEIGHT_NORM));
    end
  end

  always_ff @(posedge clk_i) begin
    pair_q <= pair_d;
    c1_q   <= in_px_i[2];
    w_q    <= w_d;
    prod_q <= prod_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    x_q    <= x_d;
    x6_q   <= x_q;
    qe_q   <= qe_d;
    res_q  <= res_d;
  end

  assign out_ctl_o = ctl_q[7];
  assign out_px_o  = res_q;

endmodule

// File: hw/rtl/rybrgb_sat.sv
// Half-saturation pipeline: max, scale, bit-per-stage divide, output register.
module rybrgb_sat import rybrgb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  ctl_t in_ctl_i,
  input  px_t  in_px_i,
  output ctl_t out_ctl_o,
  output px_t  out_px_o
);

  ctl_t             ctl1_q;
  px_t              v1_q;
  logic [7:0]       m_d, m1_q;

  // Divider stages: index 0 holds the scaled numerators, 8 the quotients.
  ctl_t             dctl_q [0:8];
  px_t              dv_q   [0:8];
  logic             dnz_q  [0:8];
  logic [8:0]       dd_q   [0:8];
  logic [2:0][16:0] rem_q  [0:8];
  logic [2:0][7:0]  quo_q  [0:8];

  logic [2:0][16:0] num_d;
  ctl_t             out_ctl_q;
  px_t              out_px_q, out_px_d;

  always_comb begin
    m_d = in_px_i[0];
    if (in_px_i[1] > m_d) m_d = in_px_i[1];
    if (in_px_i[2] > m_d) m_d = in_px_i[2];
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      num_d[j] = 17'(v1_q[j]) * 17'(9'(m1_q) + 9'd255);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q    <= '0;
      dctl_q[0] <= '0;
    end else begin
      ctl1_q    <= in_ctl_i;
      dctl_q[0] <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    v1_q     <= in_px_i;
    m1_q     <= m_d;
    dv_q[0]  <= v1_q;
    dnz_q[0] <= (m1_q != 8'd0);
    dd_q[0]  <= {m1_q, 1'b0};
    rem_q[0] <= num_d;
    quo_q[0] <= '0;
  end

  for (genvar s = 0; s < 8; s++) begin : g_div
    localparam int unsigned Bit = 7 - s;
    logic [2:0][16:0] rem_d;
    logic [2:0][7:0]  quo_d;

    // Restoring step: try divisor shifted to this quotient bit.
    always_comb begin
      logic [16:0] trial;
      logic        ge;
      trial = 17'(dd_q[s]) << Bit;
      for (int j = 0; j < 3; j++) begin
        ge       = (rem_q[s][j] >= trial);
        rem_d[j] = ge ? (rem_q[s][j] - trial) : rem_q[s][j];
        quo_d[j] = {quo_q[s][j][6:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dctl_q[s+1] <= '0;
      end else begin
        dctl_q[s+1] <= dctl_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[s+1]  <= dv_q[s];
      dnz_q[s+1] <= dnz_q[s];
      dd_q[s+1]  <= dd_q[s];
      rem_q[s+1] <= rem_d;
      quo_q[s+1] <= quo_d;
    end
  end

  // Pass black pixels and the forward direction through unchanged.
  always_comb begin
    if (dctl_q[8].dir == DIR_RGB_TO_RYB && dnz_q[8]) begin
      out_px_d = quo_q[8];
    end else begin
      out_px_d = dv_q[8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ctl_q <= '0;
    end else begin
      out_ctl_q <= dctl_q[8];
    end
  end

  always_ff @(posedge clk_i) begin
    out_px_q <= out_px_d;
  end

  assign out_ctl_o = out_ctl_q;
  assign out_px_o  = out_px_q;

endmodule

// File: hw/rtl/ryb_rgb_trilinear_convert_core.sv
// Top level of the RYB/RGB trilinear pixel converter.
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   -----------------------------
//  pixel in  in_first_i, in_second_i, in_third_i     taken when start && !busy
//  config    cfg_we_i, cfg_wdata_i (direction)       written when cfg_we_i
//  pixel out out_first_o, out_second_o, out_third_o  one word per done_o pulse
//
// One word enters per clock; each taken word passes through the pipeline's
// 7 interpolation stages and then its 11 saturation/divide/output stages.
// The eight-stage bit-serial divider of the saturation step sets the depth.
// busy stays low: the pipeline never stalls, since the receiver cannot hold
// results off. Reset clears the direction register and all valid bits.
// Write the direction only while no word is in flight.
module ryb_rgb_trilinear_convert_core import rybrgb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_first_i,
  input  logic [7:0] in_second_i,
  input  logic [7:0] in_third_i,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  output logic       done_o,
  output logic [7:0] out_first_o,
  output logic [7:0] out_second_o,
  output logic [7:0] out_third_o
);

  dir_e direction_q;
  ctl_t in_ctl, mid_ctl, out_ctl;
  px_t  in_px, mid_px, out_px;

  // Hold the conversion direction; only the low data bit matters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= DIR_RYB_TO_RGB;
    end else if (cfg_we_i) begin
      direction_q <= dir_e'(cfg_wdata_i);
    end
  end

  assign busy = 1'b0;

  // Tag every accepted word with the direction it runs under.
  assign in_ctl.valid = start && !busy;
  assign in_ctl.dir   = direction_q;
  assign in_px        = {in_third_i, in_second_i, in_first_i};

  rybrgb_interp u_interp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ctl_i  (in_ctl),
    .in_px_i   (in_px),
    .out_ctl_o (mid_ctl),
    .out_px_o  (mid_px)
  );

  rybrgb_sat u_sat (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ctl_i  (mid_ctl),
    .in_px_i   (mid_px),
    .out_ctl_o (out_ctl),
    .out_px_o  (out_px)
  );

  assign done_o       = out_ctl.valid;
  assign out_first_o  = out_px[0];
  assign out_second_o = out_px[1];
  assign out_third_o  = out_px[2];

endmodule

// File: hw/rtl/rybrgb_checker.sv
// Port-level checker of the converter core and its bind.
`include "ryb_rgb_trilinear_convert_core_defines.svh"

module rybrgb_checker import rybrgb_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [7:0] in_first_i,
  input logic [7:0] in_second_i,
  input logic [7:0] in_third_i,
  input logic       done_o,
  input logic [7:0] out_first_o,
  input logic [7:0] out_second_o,
  input logic [7:0] out_third_o
);

  logic black_in;
  logic black_out;

  assign black_in  = start && !busy && in_first_i == 8'd0 && in_second_i == 8'd0 &&
                     in_third_i == 8'd0;
  assign black_out = out_first_o == 8'd0 && out_second_o == 8'd0 && out_third_o == 8'd0;

  // A result word only follows a taken word by the fixed latency.
  `RYBRGB_ASSERT(a_done_has_word, done_o |-> $past(start && !busy, PipeLatency), "done without taken word")

  // Black stays black in both directions.
  `RYBRGB_ASSERT(a_black_kept, done_o && $past(black_in, PipeLatency) |-> black_out, "black pixel changed")

  // No result strobe while reset is applied.
  `RYBRGB_ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni |-> !done_o, "done during reset")

endmodule

bind ryb_rgb_trilinear_convert_core rybrgb_checker u_rybrgb_checker (.*);
